[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QYH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QYH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked during reset.
`define QYH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/qyh_pkg.sv]
// Shared constants, payload types and the arctangent table of the yaw heading unit.
`default_nettype none

package qyh_pkg;

   // Port field widths.
   localparam int QUAT_PORT_W = 16;
   localparam int HEAD_W      = 16;

   // Configuration port.
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam logic REG_HEADING_OFFSET = 1'b0;

   // Internal datapath widths.
   localparam int XYW  = 34;   // x and y after the products are combined
   localparam int MW   = 33;   // magnitude word used by the normalizer
   localparam int NW   = 35;   // normalized x and y
   localparam int DW   = 37;   // CORDIC x and y, with room for the gain
   localparam int AW   = 33;   // angle accumulator
   localparam int YAW_W = 17;  // rounded signed yaw
   localparam int TABLE_LEN = 24;

   // Angle constants in accumulator units (1/65536 hundredth of a degree).
   localparam logic signed [AW-1:0] QUARTER_ACC = AW'(589824000);
   localparam logic signed [AW-1:0] ROUND_HALF  = AW'(32768);
   localparam int ACC_FRAC = 16;

   // One full turn in hundredths of a degree.
   localparam logic signed [YAW_W-1:0] FULL_TURN_S = YAW_W'(36000);
   localparam logic [HEAD_W-1:0]       FULL_TURN_U = HEAD_W'(36000);

   typedef struct packed {
      logic signed [XYW-1:0] x;
      logic signed [XYW-1:0] y;
   } xy_type;

   typedef struct packed {
      logic                 zero;
      logic signed [NW-1:0] x;
      logic signed [NW-1:0] y;
   } nrm_type;

   typedef struct packed {
      logic                 zero;
      logic signed [AW-1:0] acc;
   } ang_type;

   // atan(2^-n) in accumulator units.
   function automatic logic [29:0] atan_step(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd294912000;
         5'd1:    val = 30'd174096719;
         5'd2:    val = 30'd91987925;
         5'd3:    val = 30'd46694507;
         5'd4:    val = 30'd23437865;
         5'd5:    val = 30'd11730358;
         5'd6:    val = 30'd5866610;
         5'd7:    val = 30'd2933485;
         5'd8:    val = 30'd1466764;
         5'd9:    val = 30'd733385;
         5'd10:   val = 30'd366693;
         5'd11:   val = 30'd183346;
         5'd12:   val = 30'd91673;
         5'd13:   val = 30'd45837;
         5'd14:   val = 30'd22918;
         5'd15:   val = 30'd11459;
         5'd16:   val = 30'd5730;
         5'd17:   val = 30'd2865;
         5'd18:   val = 30'd1432;
         5'd19:   val = 30'd716;
         5'd20:   val = 30'd358;
         5'd21:   val = 30'd179;
         5'd22:   val = 30'd90;
         5'd23:   val = 30'd45;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[design/qyh_stream_if.sv]
// Valid/ready channel interfaces for quaternion samples and heading results.
`default_nettype none

interface qyh_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [qyh_pkg::QUAT_PORT_W-1:0]     quat_i;
   logic signed [qyh_pkg::QUAT_PORT_W-1:0]     quat_j;
   logic signed [qyh_pkg::QUAT_PORT_W-1:0]     quat_k;
   logic signed [qyh_pkg::QUAT_PORT_W-1:0]     quat_real;

   modport source (output valid, output quat_i, output quat_j, output quat_k,
                   output quat_real, input ready);
   modport sink   (input valid, input quat_i, input quat_j, input quat_k,
                   input quat_real, output ready);
endinterface

interface qyh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [qyh_pkg::HEAD_W-1:0]        heading;

   modport source (output valid, output heading, input ready);
   modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

[design/qyh_prep.sv]
// Product stage and combine stage that form the yaw vector (x, y) from the quaternion.
`default_nettype none

module qyh_prep #(
   parameter int QUAT_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output      logic                                   in_ready,
   input  wire logic [qyh_pkg::QUAT_PORT_W-1:0]        quat_i,
   input  wire logic [qyh_pkg::QUAT_PORT_W-1:0]        quat_j,
   input  wire logic [qyh_pkg::QUAT_PORT_W-1:0]        quat_k,
   input  wire logic [qyh_pkg::QUAT_PORT_W-1:0]        quat_real,
   output      logic                                   out_valid,
   input  wire logic                                   out_ready,
   output      qyh_pkg::xy_type                        out_data
);

   localparam int PW = 2 * QUAT_WIDTH;
   localparam int PS = (QUAT_WIDTH > 16) ? 2 * (QUAT_WIDTH - 16) : 0;
   localparam int XYW = qyh_pkg::XYW;

   logic signed [QUAT_WIDTH-1:0] op_i, op_j, op_k, op_r;

   // Operands: the low bits are taken as signed at narrow widths, a wider
   // operand holds the port value with zeros above it.
   generate
      if (QUAT_WIDTH <= qyh_pkg::QUAT_PORT_W) begin : g_narrow
         assign op_i = quat_i[QUAT_WIDTH-1:0];
         assign op_j = quat_j[QUAT_WIDTH-1:0];
         assign op_k = quat_k[QUAT_WIDTH-1:0];
         assign op_r = quat_real[QUAT_WIDTH-1:0];
      end else begin : g_wide
         assign op_i = {{(QUAT_WIDTH-qyh_pkg::QUAT_PORT_W){1'b0}}, quat_i};
         assign op_j = {{(QUAT_WIDTH-qyh_pkg::QUAT_PORT_W){1'b0}}, quat_j};
         assign op_k = {{(QUAT_WIDTH-qyh_pkg::QUAT_PORT_W){1'b0}}, quat_k};
         assign op_r = {{(QUAT_WIDTH-qyh_pkg::QUAT_PORT_W){1'b0}}, quat_real};
      end
   endgenerate

   logic en1, en2;
   logic v1_ff, v2_ff;

   logic signed [PW-1:0] pij_ff, prk_ff, prr_ff, pii_ff, pjj_ff, pkk_ff;
   logic signed [PW-1:0] pij_in, prk_in, prr_in, pii_in, pjj_in, pkk_in;

   logic signed [XYW-1:0] sij, srk, srr, sii, sjj, skk;
   logic signed [XYW-1:0] x_ff, y_ff, x_in, y_in;

   // Each stage moves when it is empty or the stage after it moves.
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Stage 1: the six products.
   assign pij_in = op_i * op_j;
   assign prk_in = op_r * op_k;
   assign prr_in = op_r * op_r;
   assign pii_in = op_i * op_i;
   assign pjj_in = op_j * op_j;
   assign pkk_in = op_k * op_k;

   // Stage 2: scale the products back to Q28 and combine them.
   assign sij = XYW'(pij_ff >>> PS);
   assign srk = XYW'(prk_ff >>> PS);
   assign srr = XYW'(prr_ff >>> PS);
   assign sii = XYW'(pii_ff >>> PS);
   assign sjj = XYW'(pjj_ff >>> PS);
   assign skk = XYW'(pkk_ff >>> PS);

   assign y_in = (sij + srk) <<< 1;
   assign x_in = srr + sii - sjj - skk;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
      if (en1) begin
         pij_ff <= pij_in;
         prk_ff <= prk_in;
         prr_ff <= prr_in;
         pii_ff <= pii_in;
         pjj_ff <= pjj_in;
         pkk_ff <= pkk_in;
      end
      if (en2) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign out_valid  = v2_ff;
   assign out_data.x = x_ff;
   assign out_data.y = y_ff;

endmodule

`default_nettype wire

[design/qyh_norm.sv]
// Three-stage leading-zero normalizer that scales (x, y) until the larger magnitude reaches 2^32.
`default_nettype none

module qyh_norm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire qyh_pkg::xy_type     in_data,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      qyh_pkg::nrm_type    out_data
);

   localparam int XYW = qyh_pkg::XYW;
   localparam int MW  = qyh_pkg::MW;
   localparam int NW  = qyh_pkg::NW;

   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   logic [XYW-1:0] ax, ay;

   // Stage 1 registers: vector, magnitude word and zero flag.
   logic signed [NW-1:0] x1_ff, y1_ff, x1_in, y1_in;
   logic [MW-1:0]        m1_ff, m1_in;
   logic                 z1_ff, z1_in;

   // Stage 2 registers: coarse shifts applied.
   logic signed [NW-1:0] x2_ff, y2_ff, x2_in, y2_in;
   logic [MW-1:0]        m2_ff, m2_in;
   logic                 z2_ff;

   // Stage 3 registers: fine shifts applied.
   logic signed [NW-1:0] x3_ff, y3_ff, x3_in, y3_in;
   logic                 z3_ff;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Stage 1: magnitudes and their OR, which has the same top bit as the larger one.
   assign ax    = in_data.x[XYW-1] ? (~in_data.x + XYW'(1)) : in_data.x;
   assign ay    = in_data.y[XYW-1] ? (~in_data.y + XYW'(1)) : in_data.y;
   assign m1_in = MW'(ax | ay);
   assign z1_in = (in_data.x == '0) && (in_data.y == '0);
   assign x1_in = {{(NW-XYW){in_data.x[XYW-1]}}, in_data.x};
   assign y1_in = {{(NW-XYW){in_data.y[XYW-1]}}, in_data.y};

   // Stage 2: shift by 32, 16 and 8 where the magnitude stays below 2^33.
   always_comb begin
      x2_in = x1_ff;
      y2_in = y1_ff;
      m2_in = m1_ff;
      if (m2_in < (MW'(1) << 1)) begin
         m2_in = m2_in << 32;
         x2_in = x2_in <<< 32;
         y2_in = y2_in <<< 32;
      end
      if (m2_in < (MW'(1) << 17)) begin
         m2_in = m2_in << 16;
         x2_in = x2_in <<< 16;
         y2_in = y2_in <<< 16;
      end
      if (m2_in < (MW'(1) << 25)) begin
         m2_in = m2_in << 8;
         x2_in = x2_in <<< 8;
         y2_in = y2_in <<< 8;
      end
   end

   // Stage 3: shift by 4, 2 and 1 to land the top bit at position 32.
   always_comb begin
      logic [MW-1:0] m;
      m     = m2_ff;
      x3_in = x2_ff;
      y3_in = y2_ff;
      if (m < (MW'(1) << 29)) begin
         m     = m << 4;
         x3_in = x3_in <<< 4;
         y3_in = y3_in <<< 4;
      end
      if (m < (MW'(1) << 31)) begin
         m     = m << 2;
         x3_in = x3_in <<< 2;
         y3_in = y3_in <<< 2;
      end
      if (m < (MW'(1) << 32)) begin
         x3_in = x3_in <<< 1;
         y3_in = y3_in <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
      if (en1) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         m1_ff <= m1_in;
         z1_ff <= z1_in;
      end
      if (en2) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
         m2_ff <= m2_in;
         z2_ff <= z1_ff;
      end
      if (en3) begin
         x3_ff <= x3_in;
         y3_ff <= y3_in;
         z3_ff <= z2_ff;
      end
   end

   assign out_valid     = v3_ff;
   assign out_data.zero = z3_ff;
   assign out_data.x    = x3_ff;
   assign out_data.y    = y3_ff;

endmodule

`default_nettype wire

[design/qyh_cordic.sv]
// Pipelined vectoring CORDIC: a quadrant stage followed by one stage per micro-rotation.
`default_nettype none

module qyh_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire qyh_pkg::nrm_type    in_data,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      qyh_pkg::ang_type    out_data
);

   localparam int NW = qyh_pkg::NW;
   localparam int DW = qyh_pkg::DW;
   localparam int AW = qyh_pkg::AW;

   logic [CORDIC_STEPS:0] en;
   logic [CORDIC_STEPS:0] v_ff;
   logic [CORDIC_STEPS:0] z_ff;

   logic signed [DW-1:0] x_ff   [0:CORDIC_STEPS];
   logic signed [DW-1:0] y_ff   [0:CORDIC_STEPS];
   logic signed [AW-1:0] acc_ff [0:CORDIC_STEPS];
   logic signed [DW-1:0] x_in   [0:CORDIC_STEPS];
   logic signed [DW-1:0] y_in   [0:CORDIC_STEPS];
   logic signed [AW-1:0] acc_in [0:CORDIC_STEPS];

   logic signed [DW-1:0] xe, ye;

   // Handshake: the last stage frees up when the result is taken.
   assign en[CORDIC_STEPS] = !v_ff[CORDIC_STEPS] || out_ready;
   assign in_ready         = en[0];

   // Quadrant stage: a left-half-plane vector is turned by a quarter turn first.
   assign xe = {{(DW-NW){in_data.x[NW-1]}}, in_data.x};
   assign ye = {{(DW-NW){in_data.y[NW-1]}}, in_data.y};

   assign x_in[0]   = !xe[DW-1] ? xe : (!ye[DW-1] ? ye : -ye);
   assign y_in[0]   = !xe[DW-1] ? ye : (!ye[DW-1] ? -xe : xe);
   assign acc_in[0] = !xe[DW-1] ? '0 :
                      (!ye[DW-1] ? qyh_pkg::QUARTER_ACC : -qyh_pkg::QUARTER_ACC);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
      if (en[0]) begin
         x_ff[0]   <= x_in[0];
         y_ff[0]   <= y_in[0];
         acc_ff[0] <= acc_in[0];
         z_ff[0]   <= in_data.zero;
      end
   end

   // Micro-rotation stages: stage k drives y toward zero with shift k-1.
   generate
      for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
         localparam int SH = k - 1;
         localparam logic signed [AW-1:0] STEP = AW'(qyh_pkg::atan_step(5'(k - 1)));

         logic neg;

         if (k < CORDIC_STEPS) begin : g_en
            assign en[k] = !v_ff[k] || en[k+1];
         end

         assign neg = y_ff[k-1][DW-1];

         assign x_in[k]   = neg ? x_ff[k-1] - (y_ff[k-1] >>> SH)
                                : x_ff[k-1] + (y_ff[k-1] >>> SH);
         assign y_in[k]   = neg ? y_ff[k-1] + (x_ff[k-1] >>> SH)
                                : y_ff[k-1] - (x_ff[k-1] >>> SH);
         assign acc_in[k] = neg ? acc_ff[k-1] - STEP : acc_ff[k-1] + STEP;

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
            if (en[k]) begin
               x_ff[k]   <= x_in[k];
               y_ff[k]   <= y_in[k];
               acc_ff[k] <= acc_in[k];
               z_ff[k]   <= z_ff[k-1];
            end
         end
      end

      if (CORDIC_STEPS > 0) begin : g_en0
         assign en[0] = !v_ff[0] || en[1];
      end
   endgenerate

   assign out_valid     = v_ff[CORDIC_STEPS];
   assign out_data.zero = z_ff[CORDIC_STEPS];
   assign out_data.acc  = acc_ff[CORDIC_STEPS];

endmodule

`default_nettype wire

[design/qyh_finish.sv]
// Rounds the angle to hundredths of a degree, wraps it and removes the mounting offset.
`default_nettype none

module qyh_finish (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire qyh_pkg::ang_type              in_data,
   input  wire logic [qyh_pkg::HEAD_W-1:0]    offset_mod,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      logic [qyh_pkg::HEAD_W-1:0]    heading
);

   localparam int AW     = qyh_pkg::AW;
   localparam int YAW_W  = qyh_pkg::YAW_W;
   localparam int HEAD_W = qyh_pkg::HEAD_W;

   logic en1, en2;
   logic v1_ff, v2_ff;

   logic signed [AW-1:0]    rounded;
   logic signed [YAW_W-1:0] yaw_s, yaw_w, diff;

   logic [HEAD_W-1:0] yaw_ff, yaw_in;
   logic [HEAD_W-1:0] heading_ff, heading_in;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Stage 1: round halves upward, then wrap into one turn; a zero vector reads as 0.
   assign rounded = in_data.acc + qyh_pkg::ROUND_HALF;
   assign yaw_s   = YAW_W'(rounded >>> qyh_pkg::ACC_FRAC);
   assign yaw_w   = yaw_s[YAW_W-1] ? yaw_s + qyh_pkg::FULL_TURN_S :
                    ((yaw_s >= qyh_pkg::FULL_TURN_S) ? yaw_s - qyh_pkg::FULL_TURN_S : yaw_s);
   assign yaw_in  = in_data.zero ? '0 : yaw_w[HEAD_W-1:0];

   // Stage 2: subtract the offset and wrap a negative difference.
   assign diff       = $signed({1'b0, yaw_ff}) - $signed({1'b0, offset_mod});
   assign heading_in = diff[YAW_W-1] ? HEAD_W'(diff + qyh_pkg::FULL_TURN_S)
                                     : diff[HEAD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
      if (en1) begin
         yaw_ff <= yaw_in;
      end
      if (en2) begin
         heading_ff <= heading_in;
      end
   end

   assign out_valid = v2_ff;
   assign heading   = heading_ff;

endmodule

`default_nettype wire

[design/quaternion_yaw_heading_unit.sv]
// Top level of the quaternion yaw heading unit: offset register and the heading pipeline.
//
//   Channel   Direction  Handshake            Payload
//   req_chan  in         valid/ready          quat_i, quat_j, quat_k, quat_real (s16 Q14)
//   rsp_chan  out        valid/ready          heading (u16, hundredths of a degree)
//   csr_*     in         APB write, pready=1  heading_offset at byte address 0
//
// One quaternion is taken every cycle while no stall holds the pipeline; each
// transaction gives one heading once it has passed the registers of the
// product, normalizer, CORDIC and rounding stages.
// Synchronous reset clears all valid bits and sets the offset to 0.
// Every stage has its own valid bit and holds while it is full and the stage after it holds,
// so a stalled result lets the stages behind it fill up before req_chan.ready drops.
`default_nettype none

module quaternion_yaw_heading_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int QUAT_WIDTH   = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   qyh_req_if.sink                              req_chan,
   qyh_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [qyh_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire logic [qyh_pkg::CSR_DW-1:0]      csr_pwdata,
   output      logic [qyh_pkg::CSR_DW-1:0]      csr_prdata,
   output      logic                            csr_pready
);

   localparam int HEAD_W = qyh_pkg::HEAD_W;

   logic                 csr_write;
   logic                 offset_sel;
   logic [HEAD_W-1:0]    offset_ff, offset_in;
   logic [HEAD_W-1:0]    offset_mod_ff, offset_mod_in;

   logic                 prep_valid, prep_ready;
   qyh_pkg::xy_type      prep_data;
   logic                 norm_valid, norm_ready;
   qyh_pkg::nrm_type     norm_data;
   logic                 cordic_valid, cordic_ready;
   qyh_pkg::ang_type     cordic_data;

   // Offset register; a reduced copy keeps an out-of-range offset within one turn.
   assign csr_pready    = 1'b1;
   assign offset_sel    = (csr_paddr[2] == qyh_pkg::REG_HEADING_OFFSET);
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && offset_sel;
   assign offset_in     = csr_pwdata[HEAD_W-1:0];
   assign offset_mod_in = (offset_in >= qyh_pkg::FULL_TURN_U) ?
                          offset_in - qyh_pkg::FULL_TURN_U : offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         offset_mod_ff <= '0;
      end else if (csr_write) begin
         offset_ff     <= offset_in;
         offset_mod_ff <= offset_mod_in;
      end
   end

   assign csr_prdata = offset_sel ? {{(qyh_pkg::CSR_DW-HEAD_W){1'b0}}, offset_ff} : '0;

   // Heading pipeline.
   qyh_prep #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .quat_i    (req_chan.quat_i),
      .quat_j    (req_chan.quat_j),
      .quat_k    (req_chan.quat_k),
      .quat_real (req_chan.quat_real),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   qyh_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_data  (norm_data)
   );

   qyh_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_data   (norm_data),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_data  (cordic_data)
   );

   qyh_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cordic_valid),
      .in_ready   (cordic_ready),
      .in_data    (cordic_data),
      .offset_mod (offset_mod_ff),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .heading    (rsp_chan.heading)
   );

endmodule

`default_nettype wire

[design/qyh_checker.sv]
// Port-level checker for the quaternion yaw heading unit and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module qyh_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [qyh_pkg::HEAD_W-1:0]      rsp_heading,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [qyh_pkg::CSR_AW-1:0]      csr_paddr,
   input wire logic [qyh_pkg::CSR_DW-1:0]      csr_pwdata,
   input wire logic [qyh_pkg::CSR_DW-1:0]      csr_prdata
);

   logic                         rsp_stall;
   logic                         offset_addressed;
   logic                         offset_write;
   logic                         readback_ok;
   logic [qyh_pkg::HEAD_W-1:0]   wdata_ff;

   // Conditions that the properties below refer to.
   assign rsp_stall        = rsp_valid && !rsp_ready;
   assign offset_addressed = (csr_paddr[2] == qyh_pkg::REG_HEADING_OFFSET);
   assign offset_write     = csr_psel && csr_penable && csr_pwrite && offset_addressed;
   assign readback_ok      = !offset_addressed ||
                             (csr_prdata[qyh_pkg::HEAD_W-1:0] == wdata_ff);

   // Write data of the previous cycle.
   always_ff @(posedge clock) begin
      wdata_ff <= csr_pwdata[qyh_pkg::HEAD_W-1:0];
   end

   // A waiting result stays offered.
   `QYH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "result dropped while stalled")

   // A waiting result keeps its heading.
   `QYH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_heading), "heading moved")

   // Every heading lies within one turn.
   `QYH_ASSERT_NOW(a_heading_range, clock, reset, rsp_valid, rsp_heading < qyh_pkg::FULL_TURN_U, "heading range")

   // Reset empties the pipeline.
   `QYH_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result offered after reset")

   // A written offset reads back on the next cycle.
   `QYH_ASSERT_NEXT(a_offset_readback, clock, reset, offset_write, readback_ok, "offset readback mismatch")

endmodule

bind quaternion_yaw_heading_unit qyh_checker u_qyh_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_heading (rsp_chan.heading),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire

[tb/quaternion_yaw_heading_unit_tb.sv]
// Self-checking testbench for the quaternion yaw heading unit: directed table, then random samples.
module quaternion_yaw_heading_unit_tb;

   // Port widths taken from the package.
   localparam int QUAT_PORT_W = qyh_pkg::QUAT_PORT_W;
   localparam int HEAD_W      = qyh_pkg::HEAD_W;
   localparam int CSR_AW      = qyh_pkg::CSR_AW;
   localparam int CSR_DW      = qyh_pkg::CSR_DW;

   // Predictor constants, in hundredths of a degree or accumulator units.
   localparam int     ROTATION_STEPS  = 16;
   localparam longint TURN_HUNDREDTHS = 36000;
   localparam longint QUARTER_UNITS   = 64'sd589824000;
   localparam longint HALF_LSB        = 64'sd32768;
   localparam int     FRACTION_BITS   = 16;
   localparam longint NORM_LIMIT      = 64'sd4294967296;

   // Run shape.
   localparam int DIRECTED_ROWS   = 23;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 50;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int FINAL_WAIT      = 5000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [CSR_AW-1:0] OFFSET_ADDR =
      CSR_AW'({qyh_pkg::REG_HEADING_OFFSET, 2'b00});

   typedef struct packed {
      logic signed [QUAT_PORT_W-1:0] qi;
      logic signed [QUAT_PORT_W-1:0] qj;
      logic signed [QUAT_PORT_W-1:0] qk;
      logic signed [QUAT_PORT_W-1:0] qr;
   } quat_sample_type;

   typedef struct packed {
      quat_sample_type     q;
      logic [HEAD_W-1:0]   offset;
      logic                known;
      logic [HEAD_W-1:0]   want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   qyh_req_if req_bus ();
   qyh_rsp_if rsp_bus ();

   quaternion_yaw_heading_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [HEAD_W-1:0] pending_headings [$];
   logic [HEAD_W-1:0] offset_setting = '0;
   logic [HEAD_W-1:0] want_heading;
   longint            arctan_units [0:ROTATION_STEPS-1];
   plan_row_type      plan [0:DIRECTED_ROWS-1];
   int                error_count = 0;
   int                source_idle_pct = 0;
   int                sink_idle_pct = 0;
   bit                calm_run = 1'b0;
   int                hold_off_requests = 0;

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Heading from one quaternion: atan2 by vectoring rotations, rounding, wrap, offset.
   function automatic logic [HEAD_W-1:0] compute_heading(input quat_sample_type s,
                                                         input logic [HEAD_W-1:0] offset_reg);
      longint qi, qj, qk, qr;
      longint x, y, t, acc, dx, dy, yaw, off, h;
      int     n;
      qi = longint'($signed(s.qi));
      qj = longint'($signed(s.qj));
      qk = longint'($signed(s.qk));
      qr = longint'($signed(s.qr));
      y = 2 * (qi * qj + qr * qk);
      x = qr * qr + qi * qi - qj * qj - qk * qk;
      acc = 0;
      if (x == 0 && y == 0) begin
         yaw = 0;
      end else begin
         // Scale up until one coordinate reaches 2^32.
         while ((x < 0 ? -x : x) < NORM_LIMIT && (y < 0 ? -y : y) < NORM_LIMIT) begin
            x = x * 2;
            y = y * 2;
         end
         // Bring a left half plane vector into the right half plane first.
         if (x < 0) begin
            if (y >= 0) begin
               t = x;
               x = y;
               y = -t;
               acc = QUARTER_UNITS;
            end else begin
               t = x;
               x = -y;
               y = t;
               acc = -QUARTER_UNITS;
            end
         end
         for (n = 0; n < ROTATION_STEPS; n++) begin
            dx = y >>> n;
            dy = x >>> n;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               acc = acc + arctan_units[n];
            end else begin
               x = x - dx;
               y = y + dy;
               acc = acc - arctan_units[n];
            end
         end
         yaw = (acc + HALF_LSB) >>> FRACTION_BITS;
      end
      if (yaw < 0) yaw = yaw + TURN_HUNDREDTHS;
      if (yaw >= TURN_HUNDREDTHS) yaw = yaw - TURN_HUNDREDTHS;
      off = longint'(offset_reg);
      if (off >= TURN_HUNDREDTHS) off = off - TURN_HUNDREDTHS;
      h = yaw - off;
      if (h < 0) h = h + TURN_HUNDREDTHS;
      return h[HEAD_W-1:0];
   endfunction

   // One component: mostly full range, with small values, extremes and unit-scale values.
   function automatic logic signed [QUAT_PORT_W-1:0] random_component();
      int mode;
      int value;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         value = int'($urandom());
      end else if (mode <= 7) begin
         value = int'($urandom_range(0, 32)) - 16;
      end else if (mode == 8) begin
         case ($urandom_range(0, 3))
            0:       value = -32768;
            1:       value = 32767;
            2:       value = 0;
            default: value = -1;
         endcase
      end else begin
         value = int'($urandom_range(0, 32768)) - 16384;
      end
      return QUAT_PORT_W'(value);
   endfunction

   function automatic quat_sample_type random_sample();
      quat_sample_type s;
      s.qi = random_component();
      s.qj = random_component();
      s.qk = random_component();
      s.qr = random_component();
      // Now and then put the vector on the positive x axis.
      if ($urandom_range(0, 9) == 0) begin
         s.qj = '0;
         s.qk = '0;
      end
      return s;
   endfunction

   // Offer one sample, after an optional idle burst, and queue its heading once accepted.
   task automatic send_sample(input quat_sample_type s, input logic [HEAD_W-1:0] heading);
      int gap;
      if (!calm_run && $urandom_range(0, 99) < source_idle_pct) begin
         gap = $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.quat_i    <= s.qi;
      req_bus.quat_j    <= s.qj;
      req_bus.quat_k    <= s.qk;
      req_bus.quat_real <= s.qr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_headings.push_back(heading);
   endtask

   // Stop offering and wait until every queued heading has come out.
   task automatic drain_headings();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_headings.size() != 0) @(posedge clock);
   endtask

   // Setup and access phases of one register write.
   task automatic write_offset(input logic [HEAD_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= OFFSET_ADDR;
      csr_pwdata  <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      offset_setting = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Result side: random idle bursts, plus one long hold-off on request.
   initial begin : result_sink
      int burst;
      int hold_off_served;
      hold_off_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (!calm_run && $urandom_range(0, 99) < sink_idle_pct) begin
            burst = $urandom_range(1, 15);
            rsp_bus.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result transaction with the oldest queued heading.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_headings.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected heading %0d with none pending", rsp_bus.heading);
         end else begin
            want_heading = pending_headings.pop_front();
            if (rsp_bus.heading !== want_heading) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("heading mismatch: expected %0d, actual %0d",
                           want_heading, rsp_bus.heading);
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int              idx;
      int              phase;
      int              k;
      quat_sample_type sample;
      logic [HEAD_W-1:0] phase_offset;

      req_bus.valid     = 1'b0;
      req_bus.quat_i    = '0;
      req_bus.quat_j    = '0;
      req_bus.quat_k    = '0;
      req_bus.quat_real = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;

      arctan_units = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                       5866610, 2933485, 1466764, 733385, 366693, 183346,
                       91673, 45837, 22918, 11459};

      // Quaternion (i, j, k, r), offset, whether the heading is typed in, heading.
      plan = '{
         '{'{0, 0, 0, 0},                   0,     1'b1, 0},      // zero vector
         '{'{0, 0, 0, 16384},               0,     1'b0, 0},      // identity
         '{'{0, 0, 16384, 0},               0,     1'b0, 0},      // half turn
         '{'{0, 0, 16384, 16384},           0,     1'b0, 0},      // quarter turn
         '{'{0, 0, -16384, 16384},          0,     1'b0, 0},      // negative yaw
         '{'{0, 0, -20000, 5000},           0,     1'b0, 0},      // left half, y < 0
         '{'{0, 0, 20000, 5000},            0,     1'b0, 0},      // left half, y >= 0
         '{'{-32768, -32768, -32768, -32768}, 0,   1'b0, 0},
         '{'{32767, 32767, 32767, 32767},   0,     1'b0, 0},
         '{'{32767, -32768, 0, 0},          0,     1'b0, 0},
         '{'{-32768, 0, 0, 0},              0,     1'b0, 0},
         '{'{0, -32768, 0, 0},              0,     1'b0, 0},
         '{'{1, 0, 0, 0},                   0,     1'b0, 0},      // tiny vector
         '{'{0, 1, 1, 0},                   0,     1'b0, 0},
         '{'{1, 1, 0, 0},                   0,     1'b0, 0},
         '{'{0, 0, -1, 1},                  0,     1'b0, 0},
         '{'{-1, -32768, 32767, -1},        0,     1'b0, 0},
         '{'{0, 0, 0, 0},                   36000, 1'b1, 0},      // offset wraps to zero
         '{'{0, 0, 0, 0},                   65535, 1'b1, 6465},   // largest offset
         '{'{0, 0, 0, 0},                   35999, 1'b1, 1},      // negative difference
         '{'{0, 0, 0, 16384},               35999, 1'b0, 0},
         '{'{0, 0, 0, 0},                   1,     1'b1, 35999},
         '{'{0, 0, 16384, 16384},           1,     1'b0, 0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      source_idle_pct = 20;
      sink_idle_pct   = 4;
      for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
         if (plan[idx].offset != offset_setting) begin
            drain_headings();
            write_offset(plan[idx].offset);
         end
         send_sample(plan[idx].q, plan[idx].known ? plan[idx].want
                                                  : compute_heading(plan[idx].q, offset_setting));
      end

      // Random phases, each under its own offset; the last one runs without idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1:       phase_offset = 16'd35999;
            2:       phase_offset = 16'd65535;
            3:       phase_offset = 16'd36000;
            4:       phase_offset = HEAD_W'($urandom());
            5:       phase_offset = 16'd0;
            default: phase_offset = HEAD_W'($urandom_range(0, 35999));
         endcase
         drain_headings();
         write_offset(phase_offset);
         if (phase == RANDOM_PHASES - 1) begin
            calm_run        = 1'b1;
            source_idle_pct = 0;
            sink_idle_pct   = 0;
         end else begin
            source_idle_pct = $urandom_range(0, 2) * 20;
            sink_idle_pct   = $urandom_range(0, 2) * 4;
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // Long receiver hold-off so the pipeline fills and stalls its input.
            if (phase == 2 && k == 10) hold_off_requests++;
            sample = random_sample();
            send_sample(sample, compute_heading(sample, offset_setting));
         end
      end

      // Let the pipeline empty, then watch for stray results.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      for (k = 0; k < FINAL_WAIT && pending_headings.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_headings.size() != 0) begin
         error_count += pending_headings.size();
         $display("%0d headings never arrived", pending_headings.size());
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard limit on the length of the run.
   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/qyh_pkg.sv
design/qyh_stream_if.sv
design/qyh_prep.sv
design/qyh_norm.sv
design/qyh_cordic.sv
design/qyh_finish.sv
design/quaternion_yaw_heading_unit.sv
design/qyh_checker.sv
tb/quaternion_yaw_heading_unit_tb.sv
